[hw/rtl/bnfs_pkg.sv]
// ----------------------------------------------------------------------------
// bnfs_pkg
// Shared constants and types for the bit store with find-next-set search.
// ----------------------------------------------------------------------------
`default_nettype none

package bnfs_pkg;

    localparam int WORD_W  = 32;
    localparam int POS_W   = 5;
    localparam int INDEX_W = 10;
    localparam int REQ_W   = 3;
    localparam int WIDX_W  = INDEX_W - POS_W;

    localparam logic [REQ_W-1:0] REQ_READ      = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SET       = 3'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR_ALL = 3'd3;
    localparam logic [REQ_W-1:0] REQ_FIND      = 3'd4;

    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] tz;
    } scan_res_t;

endpackage

`default_nettype wire

[hw/rtl/bitmap_with_find_next_set_core.sv]
// ----------------------------------------------------------------------------
// bitmap_with_find_next_set_core
// Bit store of 32-bit words with read, set, clear, clear-all and
// find-next-set requests, driven by a small sequencer around one scan unit.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------------------
//   request  | in_valid / in_ready   | req_type, bit_index
//   result   | out_valid / out_ready | bit_value, found, found_index, index_error
//
// Read, set and clear pass the fetch, eval and finish states; a search passes fetch
// and stays in eval for each word scanned (at most min(NUM_WORDS, 32) words, one
// per cycle from the RAM read port); clear-all, out-of-range and unknown requests
// go straight to finish. The next request can be taken as the result turns valid.
// Reset clears the per-word valid bits, so the store reads as zero at once.
// A finished result waits in the staging stage while the output register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_with_find_next_set_core #(
    parameter int NUM_WORDS = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [bnfs_pkg::REQ_W-1:0]   req_type,
    input  wire logic [bnfs_pkg::INDEX_W-1:0] bit_index,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              bit_value,
    output logic                              found,
    output logic      [bnfs_pkg::INDEX_W-1:0] found_index,
    output logic                              index_error
);
    import bnfs_pkg::*;

    localparam int DEPTH = (NUM_WORDS < (1 << WIDX_W)) ? NUM_WORDS : (1 << WIDX_W);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_FETCH  = 4'b0010,
        S_EVAL   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [REQ_W-1:0]     req_reg, req_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [AW-1:0]        ptr_reg, ptr_next;
    logic                 first_reg, first_next;
    logic [DEPTH-1:0]     vld_reg, vld_next;
    logic                 rd_vld_reg;
    logic                 res_bit_reg, res_bit_next;
    logic                 res_found_reg, res_found_next;
    logic [INDEX_W-1:0]   res_fidx_reg, res_fidx_next;
    logic                 res_err_reg, res_err_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_bit_reg, out_bit_next;
    logic                 out_found_reg, out_found_next;
    logic [INDEX_W-1:0]   out_fidx_reg, out_fidx_next;
    logic                 out_err_reg, out_err_next;

    logic [AW-1:0]        rd_addr;
    logic [WORD_W-1:0]    rd_data;
    logic                 wr_en;
    logic [WORD_W-1:0]    wr_data;
    logic [WORD_W-1:0]    word;
    logic [WORD_W-1:0]    bit_mask;
    logic [WIDX_W-1:0]    in_widx;
    logic                 in_range;
    logic                 is_bit_op;
    scan_res_t            scan;

    bnfs_ram #(
        .WIDTH  (WORD_W),
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ptr_reg),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bnfs_scan u_scan (
        .word  (word),
        .pos   (pos_reg),
        .first (first_reg),
        .res   (scan)
    );

    assign word     = rd_vld_reg ? rd_data : '0;
    assign bit_mask = {{(WORD_W-1){1'b0}}, 1'b1} << pos_reg;
    assign in_widx  = bit_index[INDEX_W-1:POS_W];
    assign in_range = 32'(in_widx) < 32'(NUM_WORDS);
    assign is_bit_op = (req_type == REQ_READ) || (req_type == REQ_SET)
                    || (req_type == REQ_CLEAR) || (req_type == REQ_FIND);

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign bit_value   = out_bit_reg;
    assign found       = out_found_reg;
    assign found_index = out_fidx_reg;
    assign index_error = out_err_reg;

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        pos_next       = pos_reg;
        ptr_next       = ptr_reg;
        first_next     = first_reg;
        vld_next       = vld_reg;
        res_bit_next   = res_bit_reg;
        res_found_next = res_found_reg;
        res_fidx_next  = res_fidx_reg;
        res_err_next   = res_err_reg;
        out_valid_next = out_valid_reg;
        out_bit_next   = out_bit_reg;
        out_found_next = out_found_reg;
        out_fidx_next  = out_fidx_reg;
        out_err_next   = out_err_reg;
        rd_addr        = ptr_reg;
        wr_en          = 1'b0;
        wr_data        = word;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next       = req_type;
                    pos_next       = bit_index[POS_W-1:0];
                    ptr_next       = AW'(in_widx);
                    first_next     = 1'b1;
                    res_bit_next   = 1'b0;
                    res_found_next = 1'b0;
                    res_fidx_next  = '0;
                    res_err_next   = 1'b0;
                    priority if (is_bit_op && !in_range)
                    begin
                        res_err_next = 1'b1;
                        state_next   = S_FINISH;
                    end
                    else if (is_bit_op)
                    begin
                        state_next = S_FETCH;
                    end
                    else if (req_type == REQ_CLEAR_ALL)
                    begin
                        vld_next   = '0;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FETCH:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                first_next = 1'b0;
                priority if (req_reg == REQ_READ)
                begin
                    res_bit_next = word[pos_reg];
                    state_next   = S_FINISH;
                end
                else if (req_reg == REQ_SET)
                begin
                    wr_en             = 1'b1;
                    wr_data           = word | bit_mask;
                    vld_next[ptr_reg] = 1'b1;
                    state_next        = S_FINISH;
                end
                else if (req_reg == REQ_CLEAR)
                begin
                    wr_en             = 1'b1;
                    wr_data           = word & ~bit_mask;
                    vld_next[ptr_reg] = 1'b1;
                    state_next        = S_FINISH;
                end
                else if (scan.hit)
                begin
                    res_found_next = 1'b1;
                    res_fidx_next  = {WIDX_W'(ptr_reg), scan.tz};
                    state_next     = S_FINISH;
                end
                else if (ptr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                    rd_addr  = ptr_reg + AW'(1);
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_bit_next   = res_bit_reg;
                    out_found_next = res_found_reg;
                    out_fidx_next  = res_fidx_reg;
                    out_err_next   = res_err_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        pos_reg       <= pos_next;
        ptr_reg       <= ptr_next;
        first_reg     <= first_next;
        rd_vld_reg    <= vld_reg[rd_addr];
        res_bit_reg   <= res_bit_next;
        res_found_reg <= res_found_next;
        res_fidx_reg  <= res_fidx_next;
        res_err_reg   <= res_err_next;
        out_bit_reg   <= out_bit_next;
        out_found_reg <= out_found_next;
        out_fidx_reg  <= out_fidx_next;
        out_err_reg   <= out_err_next;
    end

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while a transfer is in flight");

    a_write_only_modify: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_EVAL) && ((req_reg == REQ_SET) || (req_reg == REQ_CLEAR)))
        else $error("store write outside a set or clear");

    a_clear_all_empties: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (req_type == REQ_CLEAR_ALL) |=> (vld_reg == '0))
        else $error("clear-all left valid words");

    a_found_excludes_error: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) |-> !(res_found_reg && res_err_reg))
        else $error("search hit reported together with index error");

endmodule

`default_nettype wire

[hw/rtl/bnfs_ram.sv]
// ----------------------------------------------------------------------------
// bnfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bnfs_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[hw/rtl/bnfs_scan.sv]
// ----------------------------------------------------------------------------
// bnfs_scan
// Word scan unit: masks bits below the start position on the first word,
// tests for any set bit and gives the trailing-zero count.
// ----------------------------------------------------------------------------
`default_nettype none

module bnfs_scan (
    input  wire logic [bnfs_pkg::WORD_W-1:0] word,
    input  wire logic [bnfs_pkg::POS_W-1:0]  pos,
    input  wire logic                        first,
    output bnfs_pkg::scan_res_t              res
);
    import bnfs_pkg::*;

    logic [WORD_W-1:0] masked;

    always_comb
    begin
        masked = first ? (word & ({WORD_W{1'b1}} << pos)) : word;
        res.hit = |masked;
        res.tz  = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (masked[i])
            begin
                res.tz = POS_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for bitmap_with_find_next_set_core. A directed table
// covers the extremes of the index, every request type and the reserved
// codes. Random traffic follows, alternating between dense and sparse store
// contents. A shadow bit store predicts results not in the table, and every
// result transfer is compared field by field in order. Both channels idle at
// random, and one long hold-off on the result side backs up the request side.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    import bnfs_pkg::*;

    localparam int NUM_WORDS      = 32;
    localparam int RANDOM_ITEMS   = 1250;
    localparam int DRAIN_CYCLES   = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_AFTER     = 400;
    localparam int HOLD_CYCLES    = 400;
    localparam int REPORT_MAX     = 10;

    localparam logic [REQ_W-1:0] REQ_RSVD5 = 3'd5;
    localparam logic [REQ_W-1:0] REQ_RSVD6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSVD7 = 3'd7;

    typedef struct packed {
        logic               bit_value;
        logic               found;
        logic [INDEX_W-1:0] found_index;
        logic               index_error;
    } result_t;

    typedef struct {
        logic [REQ_W-1:0]   req;
        logic [INDEX_W-1:0] idx;
        bit                 typed;
        result_t            want;
    } stim_row_t;

    localparam result_t NO_RESULT = '{1'b0, 1'b0, 10'd0, 1'b0};

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [REQ_W-1:0]   req_type;
    logic [INDEX_W-1:0] bit_index;
    logic               out_valid;
    logic               out_ready;
    logic               bit_value;
    logic               found;
    logic [INDEX_W-1:0] found_index;
    logic               index_error;

    logic [WORD_W-1:0] shadow_words [NUM_WORDS];
    result_t           expected_q [$];
    int                request_count;
    int                fail_count;
    int                report_count;
    logic              hold_off;

    stim_row_t directed_rows [25] = '{
        '{REQ_READ,      10'd0,    1'b1, NO_RESULT},
        '{REQ_FIND,      10'd0,    1'b1, NO_RESULT},
        '{REQ_READ,      10'd1023, 1'b1, NO_RESULT},
        '{REQ_SET,       10'd1023, 1'b1, NO_RESULT},
        '{REQ_READ,      10'd1023, 1'b1, '{1'b1, 1'b0, 10'd0,    1'b0}},
        '{REQ_FIND,      10'd0,    1'b1, '{1'b0, 1'b1, 10'd1023, 1'b0}},
        '{REQ_SET,       10'd0,    1'b1, NO_RESULT},
        '{REQ_FIND,      10'd0,    1'b1, '{1'b0, 1'b1, 10'd0,    1'b0}},
        '{REQ_FIND,      10'd1,    1'b1, '{1'b0, 1'b1, 10'd1023, 1'b0}},
        '{REQ_SET,       10'd31,   1'b1, NO_RESULT},
        '{REQ_FIND,      10'd1,    1'b1, '{1'b0, 1'b1, 10'd31,   1'b0}},
        '{REQ_SET,       10'd32,   1'b1, NO_RESULT},
        '{REQ_FIND,      10'd32,   1'b1, '{1'b0, 1'b1, 10'd32,   1'b0}},
        '{REQ_CLEAR,     10'd31,   1'b1, NO_RESULT},
        '{REQ_FIND,      10'd1,    1'b0, NO_RESULT},
        '{REQ_RSVD5,     10'd1023, 1'b1, NO_RESULT},
        '{REQ_RSVD6,     10'd0,    1'b1, NO_RESULT},
        '{REQ_RSVD7,     10'd682,  1'b1, NO_RESULT},
        '{REQ_SET,       10'd341,  1'b0, NO_RESULT},
        '{REQ_FIND,      10'd33,   1'b0, NO_RESULT},
        '{REQ_CLEAR_ALL, 10'd1023, 1'b1, NO_RESULT},
        '{REQ_FIND,      10'd0,    1'b1, NO_RESULT},
        '{REQ_READ,      10'd0,    1'b1, NO_RESULT},
        '{REQ_SET,       10'd511,  1'b0, NO_RESULT},
        '{REQ_FIND,      10'd480,  1'b0, NO_RESULT}
    };

    bitmap_with_find_next_set_core #(
        .NUM_WORDS (NUM_WORDS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .bit_index   (bit_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .bit_value   (bit_value),
        .found       (found),
        .found_index (found_index),
        .index_error (index_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic result_t predict_result(input logic [REQ_W-1:0] req,
                                               input logic [INDEX_W-1:0] idx);
        result_t           r;
        int unsigned       word_no;
        int unsigned       pos;
        logic [WORD_W-1:0] w;
        r       = NO_RESULT;
        word_no = idx >> POS_W;
        pos     = idx % WORD_W;
        if (req == REQ_READ || req == REQ_SET || req == REQ_CLEAR || req == REQ_FIND)
        begin
            if (word_no >= NUM_WORDS)
                r.index_error = 1'b1;
            else if (req == REQ_READ)
                r.bit_value = shadow_words[word_no][pos];
            else if (req == REQ_SET)
                shadow_words[word_no][pos] = 1'b1;
            else if (req == REQ_CLEAR)
                shadow_words[word_no][pos] = 1'b0;
            else
            begin
                w = shadow_words[word_no] & ({WORD_W{1'b1}} << pos);
                for (int u = word_no; u < NUM_WORDS && !r.found; u++)
                begin
                    if (u != word_no)
                        w = shadow_words[u];
                    for (int b = 0; b < WORD_W && !r.found; b++)
                    begin
                        if (w[b])
                        begin
                            r.found       = 1'b1;
                            r.found_index = INDEX_W'(u * WORD_W + b);
                        end
                    end
                end
            end
        end
        else if (req == REQ_CLEAR_ALL)
        begin
            for (int u = 0; u < NUM_WORDS; u++)
                shadow_words[u] = '0;
        end
        return r;
    endfunction

    task automatic send_request(input logic [REQ_W-1:0] req, input logic [INDEX_W-1:0] idx,
                                input bit typed, input result_t want, input bit no_idle);
        int      gap;
        result_t predicted;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= req;
        bit_index <= idx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = predict_result(req, idx);
        expected_q.push_back(typed ? want : predicted);
        request_count++;
    endtask

    initial
    begin : stimulus
        int                 useful;
        int                 pick;
        int                 set_share;
        logic [REQ_W-1:0]   req;
        logic [INDEX_W-1:0] idx;
        logic [INDEX_W-1:0] last_set;
        bit                 no_idle;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        req_type      = REQ_READ;
        bit_index     = '0;
        request_count = 0;
        fail_count    = 0;
        report_count  = 0;
        last_set      = '0;
        useful        = 0;
        for (int u = 0; u < NUM_WORDS; u++)
            shadow_words[u] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].idx,
                         directed_rows[i].typed, directed_rows[i].want, 1'b0);

        while (useful < RANDOM_ITEMS)
        begin
            pick      = $urandom_range(0, 99);
            set_share = ((useful / 200) % 2 == 0) ? 45 : 15;
            if (pick < 1)
                req = REQ_CLEAR_ALL;
            else if (pick < 5)
                req = REQ_W'($urandom_range(REQ_RSVD5, REQ_RSVD7));
            else if (pick < 5 + set_share)
                req = REQ_SET;
            else if (pick < 20 + set_share)
                req = REQ_CLEAR;
            else if (pick < 35 + set_share)
                req = REQ_READ;
            else
                req = REQ_FIND;
            case ($urandom_range(0, 3))
                0:       idx = INDEX_W'($urandom);
                1:       idx = {WIDX_W'($urandom), POS_W'($urandom_range(0, 1) * 31)};
                2:       idx = last_set - INDEX_W'($urandom_range(0, 40));
                default: idx = INDEX_W'($urandom_range(960, 1023));
            endcase
            if (req == REQ_SET)
                last_set = idx;
            no_idle = ((useful / 100) % 4 == 1);
            send_request(req, idx, 1'b0, NO_RESULT, no_idle);
            if (req <= REQ_FIND)
                useful++;
        end
        in_valid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin : result_side
        int stall;
        int results;
        out_ready = 1'b0;
        results   = 0;
        wait (rst_n);
        forever
        begin
            stall = ((results / 80) % 3 == 1) ? 0 : $urandom_range(0, 9);
            if (stall > 0 || hold_off)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
                while (hold_off)
                    @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            results++;
        end
    end

    initial
    begin : backpressure
        hold_off = 1'b0;
        wait (request_count >= HOLD_AFTER);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{bit_value, found, found_index, index_error};
            if (expected_q.size() == 0)
            begin
                fail_count++;
                if (report_count < REPORT_MAX)
                begin
                    report_count++;
                    $display("unexpected result transfer: bit=%0b found=%0b index=%0d err=%0b",
                             got.bit_value, got.found, got.found_index, got.index_error);
                end
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.bit_value !== want.bit_value || got.found !== want.found ||
                    got.found_index !== want.found_index ||
                    got.index_error !== want.index_error)
                begin
                    fail_count++;
                    if (report_count < REPORT_MAX)
                    begin
                        report_count++;
                        $display("result mismatch: expected bit=%0b found=%0b index=%0d err=%0b",
                                 want.bit_value, want.found, want.found_index,
                                 want.index_error);
                        $display("                 actual   bit=%0b found=%0b index=%0d err=%0b",
                                 got.bit_value, got.found, got.found_index,
                                 got.index_error);
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
